// ----- rtl/rsp_pkg.sv -----
// Shared types and constants for the ray/sphere pick unit.
// No dependencies; every other file imports this package.
`default_nettype none
package rsp_pkg;

  localparam int SPHERE_COUNT_DEF = 8;
  localparam int COORD_BITS_DEF   = 24;
  localparam int RADIUS_BITS      = 23;
  localparam int SLOT_BITS        = 3;
  localparam int STEP_BITS        = 5;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  localparam logic [STEP_BITS-1:0] STEP_LAST = STEP_BITS'(23);

  typedef enum logic [2:0] {
    D_NONE,
    D_DD,
    D_CC,
    D_DOT,
    D_RR,
    D_ACC
  } dest_t;

  typedef enum logic [1:0] {
    SH_0,
    SH_1,
    SH_2
  } shf_t;

  typedef struct packed {
    logic                 done;
    logic                 hit;
    logic [SLOT_BITS-1:0] slot;
  } pick_t;

endpackage
`default_nettype wire

// ----- rtl/rsp_query_if.sv -----
// Input channel of the pick unit: load and query words.
// Depends on rsp_pkg.
`default_nettype none
interface rsp_query_if
  import rsp_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic                          mode;
  logic [SLOT_BITS-1:0]          slot;
  logic signed [COORD_BITS-1:0]  point_x;
  logic signed [COORD_BITS-1:0]  point_y;
  logic signed [COORD_BITS-1:0]  point_z;
  logic signed [COORD_BITS-1:0]  ray_end_x;
  logic signed [COORD_BITS-1:0]  ray_end_y;
  logic signed [COORD_BITS-1:0]  ray_end_z;
  logic [RADIUS_BITS-1:0]        radius;

  modport source (
    output valid, mode, slot, point_x, point_y, point_z,
           ray_end_x, ray_end_y, ray_end_z, radius,
    input  ready
  );
  modport sink (
    input  valid, mode, slot, point_x, point_y, point_z,
           ray_end_x, ray_end_y, ray_end_z, radius,
    output ready
  );
endinterface
`default_nettype wire

// ----- rtl/rsp_pick_if.sv -----
// Output channel of the pick unit: one hit word per query.
// Depends on rsp_pkg.
`default_nettype none
interface rsp_pick_if
  import rsp_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic                 hit;
  logic [SLOT_BITS-1:0] hit_slot;

  modport source (output valid, hit, hit_slot, input ready);
  modport sink (input valid, hit, hit_slot, output ready);
endinterface
`default_nettype wire

// ----- rtl/rsp_cell.sv -----
// One sphere cell: holds a sphere, runs the squared hit test on its own
// multiplier and passes the ray and the running pick to its neighbor. Uses rsp_pkg.
`default_nettype none
module rsp_cell
  import rsp_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int IDX        = 0
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         load_en,
  input  logic [SLOT_BITS-1:0]         load_slot,
  input  logic signed [COORD_BITS-1:0] load_x,
  input  logic signed [COORD_BITS-1:0] load_y,
  input  logic signed [COORD_BITS-1:0] load_z,
  input  logic [RADIUS_BITS-1:0]       load_radius,
  input  logic                         in_start,
  input  logic signed [COORD_BITS-1:0] in_sx,
  input  logic signed [COORD_BITS-1:0] in_sy,
  input  logic signed [COORD_BITS-1:0] in_sz,
  input  logic signed [COORD_BITS:0]   in_dx,
  input  logic signed [COORD_BITS:0]   in_dy,
  input  logic signed [COORD_BITS:0]   in_dz,
  input  pick_t                        in_pick,
  output logic                         out_start,
  output logic signed [COORD_BITS-1:0] out_sx,
  output logic signed [COORD_BITS-1:0] out_sy,
  output logic signed [COORD_BITS-1:0] out_sz,
  output logic signed [COORD_BITS:0]   out_dx,
  output logic signed [COORD_BITS:0]   out_dy,
  output logic signed [COORD_BITS:0]   out_dz,
  output pick_t                        out_pick
);

  localparam int CB = COORD_BITS;
  localparam int H  = (CB + 2 > RADIUS_BITS + 1) ? CB + 2 : RADIUS_BITS + 1;
  localparam int W  = 2 * H;
  localparam int A  = 4 * H;
  localparam logic [SLOT_BITS-1:0] IDX_SLOT = SLOT_BITS'(IDX);

  logic signed [CB-1:0]    cx;
  logic signed [CB-1:0]    cy;
  logic signed [CB-1:0]    cz;
  logic [RADIUS_BITS-1:0]  rad;
  logic signed [CB:0]      c0;
  logic signed [CB:0]      c1;
  logic signed [CB:0]      c2;
  logic signed [CB:0]      d0;
  logic signed [CB:0]      d1;
  logic signed [CB:0]      d2;
  logic [W-1:0]            dd;
  logic [W-1:0]            cc;
  logic [W-1:0]            rr;
  logic signed [W-1:0]     dot;
  logic signed [A-1:0]     acc;
  logic                    active;
  logic [STEP_BITS-1:0]    step;
  logic signed [2*H+1:0]   prod;
  dest_t                   pdest;
  shf_t                    pshift;
  logic                    pneg;

  logic signed [H:0]       mop_a;
  logic signed [H:0]       mop_b;
  dest_t                   mdest;
  shf_t                    mshift;
  logic                    mneg;
  logic signed [H:0]       dd_lo;
  logic signed [H:0]       dd_hi;
  logic signed [H:0]       cc_lo;
  logic signed [H:0]       cc_hi;
  logic signed [H:0]       rr_lo;
  logic signed [H:0]       rr_hi;
  logic signed [H:0]       dot_lo;
  logic signed [H:0]       dot_hi;
  logic signed [A-1:0]     ext;
  logic signed [A-1:0]     term;
  logic                    own_hit;
  logic                    finish;

  assign dd_lo  = {1'b0, dd[H-1:0]};
  assign dd_hi  = {1'b0, dd[W-1:H]};
  assign cc_lo  = {1'b0, cc[H-1:0]};
  assign cc_hi  = {1'b0, cc[W-1:H]};
  assign rr_lo  = {1'b0, rr[H-1:0]};
  assign rr_hi  = {1'b0, rr[W-1:H]};
  assign dot_lo = {1'b0, dot[H-1:0]};
  assign dot_hi = {1'b0, dot[W-1:H]};

  assign finish  = active && (step == STEP_LAST);
  assign own_hit = (dd != '0) && !dot[W-1] && !acc[A-1] && (acc != '0);

  // multiply schedule: |d|^2, |c|^2, dot, r^2, then rr*dd + dot^2 - cc*dd
  always_comb begin
    mop_a  = '0;
    mop_b  = '0;
    mdest  = D_NONE;
    mshift = SH_0;
    mneg   = 1'b0;
    if (active) begin
      case (step)
        5'd0:  begin mop_a = (H+1)'(d0); mop_b = (H+1)'(d0); mdest = D_DD; end
        5'd1:  begin mop_a = (H+1)'(d1); mop_b = (H+1)'(d1); mdest = D_DD; end
        5'd2:  begin mop_a = (H+1)'(d2); mop_b = (H+1)'(d2); mdest = D_DD; end
        5'd3:  begin mop_a = (H+1)'(c0); mop_b = (H+1)'(c0); mdest = D_CC; end
        5'd4:  begin mop_a = (H+1)'(c1); mop_b = (H+1)'(c1); mdest = D_CC; end
        5'd5:  begin mop_a = (H+1)'(c2); mop_b = (H+1)'(c2); mdest = D_CC; end
        5'd6:  begin mop_a = (H+1)'(c0); mop_b = (H+1)'(d0); mdest = D_DOT; end
        5'd7:  begin mop_a = (H+1)'(c1); mop_b = (H+1)'(d1); mdest = D_DOT; end
        5'd8:  begin mop_a = (H+1)'(c2); mop_b = (H+1)'(d2); mdest = D_DOT; end
        5'd9:  begin
          mop_a = {1'b0, (H)'(rad)};
          mop_b = {1'b0, (H)'(rad)};
          mdest = D_RR;
        end
        5'd10: begin mop_a = cc_lo; mop_b = dd_lo; mdest = D_ACC; mneg = 1'b1; end
        5'd11: begin
          mop_a = cc_lo; mop_b = dd_hi; mdest = D_ACC; mshift = SH_1; mneg = 1'b1;
        end
        5'd12: begin
          mop_a = cc_hi; mop_b = dd_lo; mdest = D_ACC; mshift = SH_1; mneg = 1'b1;
        end
        5'd13: begin
          mop_a = cc_hi; mop_b = dd_hi; mdest = D_ACC; mshift = SH_2; mneg = 1'b1;
        end
        5'd14: begin mop_a = dot_lo; mop_b = dot_lo; mdest = D_ACC; end
        5'd15: begin mop_a = dot_lo; mop_b = dot_hi; mdest = D_ACC; mshift = SH_1; end
        5'd16: begin mop_a = dot_hi; mop_b = dot_lo; mdest = D_ACC; mshift = SH_1; end
        5'd17: begin mop_a = dot_hi; mop_b = dot_hi; mdest = D_ACC; mshift = SH_2; end
        5'd18: begin mop_a = rr_lo; mop_b = dd_lo; mdest = D_ACC; end
        5'd19: begin mop_a = rr_lo; mop_b = dd_hi; mdest = D_ACC; mshift = SH_1; end
        5'd20: begin mop_a = rr_hi; mop_b = dd_lo; mdest = D_ACC; mshift = SH_1; end
        5'd21: begin mop_a = rr_hi; mop_b = dd_hi; mdest = D_ACC; mshift = SH_2; end
        default: begin
          mdest = D_NONE;
        end
      endcase
    end
  end

  always_comb begin
    ext = A'(prod);
    case (pshift)
      SH_1:    term = ext <<< H;
      SH_2:    term = ext <<< W;
      default: term = ext;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cx       <= '0;
      cy       <= '0;
      cz       <= '0;
      rad      <= '0;
      active   <= 1'b0;
      step     <= '0;
      pdest    <= D_NONE;
      pshift   <= SH_0;
      pneg     <= 1'b0;
      out_start <= 1'b0;
      out_pick <= '0;
    end else begin
      out_start <= in_start;
      pdest     <= mdest;
      pshift    <= mshift;
      pneg      <= mneg;
      if (load_en && (load_slot == IDX_SLOT) && (IDX < (1 << SLOT_BITS))) begin
        cx  <= load_x;
        cy  <= load_y;
        cz  <= load_z;
        rad <= load_radius;
      end
      if (in_start) begin
        active <= 1'b1;
        step   <= '0;
      end else if (active) begin
        step <= step + 1'b1;
        if (finish) begin
          active <= 1'b0;
        end
      end
      if (finish) begin
        out_pick <= '{done: 1'b1,
                      hit:  in_pick.hit | own_hit,
                      slot: in_pick.hit ? in_pick.slot : (own_hit ? IDX_SLOT : '0)};
      end else begin
        out_pick <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod   <= mop_a * mop_b;
    out_sx <= in_sx;
    out_sy <= in_sy;
    out_sz <= in_sz;
    out_dx <= in_dx;
    out_dy <= in_dy;
    out_dz <= in_dz;
    if (in_start) begin
      c0  <= (CB+1)'(cx) - (CB+1)'(in_sx);
      c1  <= (CB+1)'(cy) - (CB+1)'(in_sy);
      c2  <= (CB+1)'(cz) - (CB+1)'(in_sz);
      d0  <= in_dx;
      d1  <= in_dy;
      d2  <= in_dz;
      dd  <= '0;
      cc  <= '0;
      rr  <= '0;
      dot <= '0;
      acc <= '0;
    end else begin
      case (pdest)
        D_DD:    dd  <= dd + prod[W-1:0];
        D_CC:    cc  <= cc + prod[W-1:0];
        D_DOT:   dot <= dot + $signed(prod[W-1:0]);
        D_RR:    rr  <= rr + prod[W-1:0];
        D_ACC:   acc <= pneg ? acc - term : acc + term;
        default: ;
      endcase
    end
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    in_start |-> !active)
    else $error("rsp_cell: start while busy");

  a_aligned: assert property (@(posedge clk) disable iff (rst)
    finish |-> (in_pick.done || IDX == 0))
    else $error("rsp_cell: neighbor pick not aligned");

  a_one_shot: assert property (@(posedge clk) disable iff (rst)
    finish |=> (!active && out_pick.done))
    else $error("rsp_cell: finish did not retire");

endmodule
`default_nettype wire

// ----- rtl/ray_sphere_pick_unit.sv -----
// Ray pick over a table of spheres: a chain of sphere cells, one per slot.
// A query word is registered into the launch stage, runs the 24-step multiply
// schedule in each cell and is passed from cell to cell through their registers
// before its result is offered. No word is taken while a query is in flight or
// the two-word output queue is full; otherwise loads are taken one per cycle.
// Reset clears every sphere to zero. Depends on rsp_pkg, the interfaces, rsp_cell.
`default_nettype none
module ray_sphere_pick_unit
  import rsp_pkg::*;
#(
  parameter int SPHERE_COUNT = SPHERE_COUNT_DEF,
  parameter int COORD_BITS   = COORD_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  rsp_query_if.sink  query,
  rsp_pick_if.source pick
);

  localparam int CB = COORD_BITS;

  logic                 busy;
  logic [1:0]           count;
  logic                 e0_hit;
  logic [SLOT_BITS-1:0] e0_slot;
  logic                 e1_hit;
  logic [SLOT_BITS-1:0] e1_slot;
  logic                 start;
  logic signed [CB-1:0] sx;
  logic signed [CB-1:0] sy;
  logic signed [CB-1:0] sz;
  logic signed [CB:0]   dx;
  logic signed [CB:0]   dy;
  logic signed [CB:0]   dz;

  logic                 take;
  logic                 take_query;
  logic                 load_en;
  logic                 push;
  logic                 pop;

  logic                 ch_start [0:SPHERE_COUNT];
  logic signed [CB-1:0] ch_sx    [0:SPHERE_COUNT];
  logic signed [CB-1:0] ch_sy    [0:SPHERE_COUNT];
  logic signed [CB-1:0] ch_sz    [0:SPHERE_COUNT];
  logic signed [CB:0]   ch_dx    [0:SPHERE_COUNT];
  logic signed [CB:0]   ch_dy    [0:SPHERE_COUNT];
  logic signed [CB:0]   ch_dz    [0:SPHERE_COUNT];
  pick_t                ch_pick  [0:SPHERE_COUNT];

  assign query.ready = !busy && (count != 2'd2);
  assign take        = query.valid && query.ready;
  assign take_query  = take && (query.mode == MODE_QUERY);
  assign load_en     = take && (query.mode == MODE_LOAD);
  assign push        = ch_pick[SPHERE_COUNT].done;
  assign pop         = pick.valid && pick.ready;

  assign pick.valid    = (count != 2'd0);
  assign pick.hit      = e0_hit;
  assign pick.hit_slot = e0_slot;

  assign ch_start[0] = start;
  assign ch_sx[0]    = sx;
  assign ch_sy[0]    = sy;
  assign ch_sz[0]    = sz;
  assign ch_dx[0]    = dx;
  assign ch_dy[0]    = dy;
  assign ch_dz[0]    = dz;
  assign ch_pick[0]  = '0;

  for (genvar i = 0; i < SPHERE_COUNT; i++) begin : g_cell
    rsp_cell #(
      .COORD_BITS (COORD_BITS),
      .IDX        (i)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .load_en     (load_en),
      .load_slot   (query.slot),
      .load_x      (query.point_x),
      .load_y      (query.point_y),
      .load_z      (query.point_z),
      .load_radius (query.radius),
      .in_start    (ch_start[i]),
      .in_sx       (ch_sx[i]),
      .in_sy       (ch_sy[i]),
      .in_sz       (ch_sz[i]),
      .in_dx       (ch_dx[i]),
      .in_dy       (ch_dy[i]),
      .in_dz       (ch_dz[i]),
      .in_pick     (ch_pick[i]),
      .out_start   (ch_start[i+1]),
      .out_sx      (ch_sx[i+1]),
      .out_sy      (ch_sy[i+1]),
      .out_sz      (ch_sz[i+1]),
      .out_dx      (ch_dx[i+1]),
      .out_dy      (ch_dy[i+1]),
      .out_dz      (ch_dz[i+1]),
      .out_pick    (ch_pick[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      start <= 1'b0;
      count <= '0;
    end else begin
      start <= take_query;
      if (take_query) begin
        busy <= 1'b1;
      end else if (push) begin
        busy <= 1'b0;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  // hold ray and the two-word output queue
  always_ff @(posedge clk) begin
    if (take_query) begin
      sx <= query.point_x;
      sy <= query.point_y;
      sz <= query.point_z;
      dx <= (CB+1)'(query.ray_end_x) - (CB+1)'(query.point_x);
      dy <= (CB+1)'(query.ray_end_y) - (CB+1)'(query.point_y);
      dz <= (CB+1)'(query.ray_end_z) - (CB+1)'(query.point_z);
    end
    if (pop && count == 2'd2) begin
      e0_hit  <= e1_hit;
      e0_slot <= e1_slot;
    end
    if (push && (count == 2'd0 || (count == 2'd1 && pop))) begin
      e0_hit  <= ch_pick[SPHERE_COUNT].hit;
      e0_slot <= ch_pick[SPHERE_COUNT].slot;
    end
    if (push && ((count == 2'd1 && !pop) || (count == 2'd2 && pop))) begin
      e1_hit  <= ch_pick[SPHERE_COUNT].hit;
      e1_slot <= ch_pick[SPHERE_COUNT].slot;
    end
  end

  a_push_busy: assert property (@(posedge clk) disable iff (rst)
    push |-> busy)
    else $error("pick word without a query in flight");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (count != 2'd2 || pop))
    else $error("output queue overflow");

  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    take_query |=> (busy && start))
    else $error("query not launched");

endmodule
`default_nettype wire

// ----- tb/tb_ray_sphere_pick_unit.sv -----
// Self-checking bench for ray_sphere_pick_unit: drives load and query words,
// predicts each pick with exact wide arithmetic and scores the hit words.
// Depends on rsp_pkg, rsp_query_if, rsp_pick_if and the unit itself.
`default_nettype none
module tb_ray_sphere_pick_unit
  import rsp_pkg::*;
;

  localparam int NSPH = SPHERE_COUNT_DEF;
  localparam int CB = COORD_BITS_DEF;
  localparam int RUN_LIMIT = 400000;

  typedef logic signed [CB-1:0] coord_t;

  class pick_board;
    coord_t cx[NSPH], cy[NSPH], cz[NSPH];
    logic [RADIUS_BITS-1:0] rad[NSPH];
    logic [SLOT_BITS:0] pending[$];
    int errors;
    int picks;
    int hits;

    function void clear();
      foreach (cx[i]) begin
        cx[i] = '0; cy[i] = '0; cz[i] = '0; rad[i] = '0;
      end
      errors = 0; picks = 0; hits = 0;
    endfunction

    function bit sphere_hit(int i, coord_t sx, coord_t sy, coord_t sz,
                            coord_t ex, coord_t ey, coord_t ez);
      logic signed [31:0] c0, c1, c2, d0, d1, d2;
      logic signed [127:0] dot, cc, dd, rr, lhs, rhs;
      c0 = cx[i] - sx; c1 = cy[i] - sy; c2 = cz[i] - sz;
      d0 = ex - sx; d1 = ey - sy; d2 = ez - sz;
      dd = d0 * d0 + d1 * d1 + d2 * d2;
      cc = c0 * c0 + c1 * c1 + c2 * c2;
      dot = c0 * d0 + c1 * d1 + c2 * d2;
      rr = {105'd0, rad[i]};
      if (dd == 0 || dot < 0) return 0;
      lhs = cc * dd;
      rhs = dot * dot + rr * rr * dd;
      return lhs < rhs;
    endfunction

    function void note_word(logic mode, logic [SLOT_BITS-1:0] slot, coord_t px,
                            coord_t py, coord_t pz, coord_t ex, coord_t ey,
                            coord_t ez, logic [RADIUS_BITS-1:0] r);
      logic [SLOT_BITS:0] res;
      if (mode == MODE_LOAD) begin
        if (slot < NSPH) begin
          cx[slot] = px; cy[slot] = py; cz[slot] = pz; rad[slot] = r;
        end
        return;
      end
      res = '0;
      for (int i = 0; i < NSPH; i++)
        if (sphere_hit(i, px, py, pz, ex, ey, ez)) begin
          res = {1'b1, SLOT_BITS'(i)};
          break;
        end
      pending.push_back(res);
    endfunction

    function void check_pick(logic h, logic [SLOT_BITS-1:0] s);
      logic [SLOT_BITS:0] e;
      picks++;
      if (pending.size() == 0) begin
        $error("unexpected pick word hit=%0d slot=%0d", h, s);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (h) hits++;
      if (h !== e[SLOT_BITS]) begin
        $error("hit: expected %0d actual %0d", e[SLOT_BITS], h);
        errors++;
      end
      if (s !== e[SLOT_BITS-1:0]) begin
        $error("hit_slot: expected %0d actual %0d", e[SLOT_BITS-1:0], s);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  int cycle = 0;
  bit quiet = 0;
  pick_board board;

  rsp_query_if #(.COORD_BITS(CB)) query ();
  rsp_pick_if pick ();

  ray_sphere_pick_unit u_dut (.clk(clk), .rst(rst), .query(query), .pick(pick));

  always #2 clk = ~clk;

  initial begin
    query.valid = 0; query.mode = MODE_LOAD; query.slot = '0;
    query.point_x = '0; query.point_y = '0; query.point_z = '0;
    query.ray_end_x = '0; query.ray_end_y = '0; query.ray_end_z = '0;
    query.radius = '0; pick.ready = 0;
  end

  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > RUN_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && pick.valid && pick.ready) board.check_pick(pick.hit, pick.hit_slot);
  end

  int sink_gap = 0;
  always @(posedge clk) begin
    if (rst) pick.ready <= 0;
    else if (sink_gap > 0) begin
      sink_gap <= sink_gap - 1;
      pick.ready <= 0;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      sink_gap <= $urandom_range(1, 11) - 1;
      pick.ready <= 0;
    end else pick.ready <= 1;
  end

  task automatic send_word(logic mode, logic [SLOT_BITS-1:0] slot, coord_t px,
                           coord_t py, coord_t pz, coord_t ex, coord_t ey,
                           coord_t ez, logic [RADIUS_BITS-1:0] r);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      query.valid <= 0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    query.valid <= 1; query.mode <= mode; query.slot <= slot;
    query.point_x <= px; query.point_y <= py; query.point_z <= pz;
    query.ray_end_x <= ex; query.ray_end_y <= ey; query.ray_end_z <= ez;
    query.radius <= r;
    @(posedge clk);
    while (!query.ready) @(posedge clk);
    board.note_word(mode, slot, px, py, pz, ex, ey, ez, r);
  endtask

  function automatic coord_t rand_coord(int spread);
    case ($urandom_range(0, 3))
      0: return coord_t'($urandom);
      default: return coord_t'($signed($urandom_range(0, 2 * spread)) - spread);
    endcase
  endfunction

  task automatic load_sphere(int s, coord_t x, coord_t y, coord_t z,
                             logic [RADIUS_BITS-1:0] r);
    send_word(MODE_LOAD, SLOT_BITS'(s), x, y, z, coord_t'($urandom),
              coord_t'($urandom), coord_t'($urandom), r);
  endtask

  task automatic cast_ray(coord_t sx, coord_t sy, coord_t sz,
                          coord_t ex, coord_t ey, coord_t ez);
    send_word(MODE_QUERY, SLOT_BITS'($urandom), sx, sy, sz, ex, ey, ez,
              RADIUS_BITS'($urandom));
  endtask

  task automatic aim_ray(int spread);
    int s;
    coord_t sx, sy, sz;
    s = $urandom_range(0, NSPH - 1);
    sx = rand_coord(spread); sy = rand_coord(spread); sz = rand_coord(spread);
    cast_ray(sx, sy, sz,
             board.cx[s] + coord_t'(($signed($urandom_range(0, 2 * spread)) - spread) / 4),
             board.cy[s] + coord_t'(($signed($urandom_range(0, 2 * spread)) - spread) / 4),
             board.cz[s] + coord_t'(($signed($urandom_range(0, 2 * spread)) - spread) / 4));
  endtask

  localparam coord_t CMAX = {1'b0, {(CB-1){1'b1}}};
  localparam coord_t CMIN = {1'b1, {(CB-1){1'b0}}};
  localparam logic [RADIUS_BITS-1:0] RMAX = '1;

  initial begin
    int spread;
    board = new();
    board.clear();
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    cast_ray(0, 0, 0, 24'sd65536, 0, 0);
    load_sphere(3, 24'sd655360, 0, 0, 23'd65536);
    load_sphere(5, 0, 24'sd655360, 0, 23'd131072);
    cast_ray(0, 0, 0, 24'sd65536, 0, 0);
    cast_ray(0, 0, 0, 0, 24'sd65536, 0);
    cast_ray(24'sd100, 24'sd100, 24'sd100, 24'sd100, 24'sd100, 24'sd100);
    cast_ray(24'sd655360, 24'sd65536, 0, 24'sd655360, 24'sd131072, 0);
    cast_ray(0, 0, 0, -24'sd65536, 0, 0);
    load_sphere(1, 24'sd655360, 0, 0, 0);
    cast_ray(0, 0, 0, 24'sd655360, 0, 0);
    cast_ray(0, 24'sd65536, 0, 24'sd655360, 24'sd65536, 0);
    load_sphere(0, CMAX, CMAX, CMAX, RMAX);
    load_sphere(7, CMIN, CMIN, CMIN, RMAX);
    cast_ray(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX);
    cast_ray(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN);
    cast_ray(CMAX, CMIN, CMAX, CMIN, CMAX, CMIN);
    load_sphere(2, 0, 0, 0, RMAX);
    cast_ray(0, 0, 0, CMAX, 0, 0);
    query.valid <= 0;

    while (board.pending.size() != 0) @(posedge clk);

    for (int n = 0; n < 1330; n++) begin
      if (n == 1150) quiet = 1;
      spread = ($urandom_range(0, 3) == 0) ? 8388607 : 2000000;
      case ($urandom_range(0, 9))
        0, 1, 2: load_sphere($urandom_range(0, NSPH - 1), rand_coord(spread),
                             rand_coord(spread), rand_coord(spread),
                             ($urandom_range(0, 5) == 0) ? RADIUS_BITS'($urandom)
                             : RADIUS_BITS'($urandom_range(0, spread / 2)));
        3, 4, 5, 6: aim_ray(spread);
        7: cast_ray(rand_coord(spread), rand_coord(spread), rand_coord(spread),
                    rand_coord(spread), rand_coord(spread), rand_coord(spread));
        default: begin
          spread = $urandom_range(0, 2);
          if (spread == 0) cast_ray(CMAX, 0, CMIN, CMAX, 0, CMIN);
          else aim_ray(65536);
        end
      endcase
    end
    query.valid <= 0;

    while (board.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    $display("picks scored: %0d, of which hits: %0d", board.picks, board.hits);
    if (board.errors == 0 && board.pending.size() == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule
`default_nettype wire

// ----- files.f -----
rtl/rsp_pkg.sv
rtl/rsp_query_if.sv
rtl/rsp_pick_if.sv
rtl/rsp_cell.sv
rtl/ray_sphere_pick_unit.sv
tb/tb_ray_sphere_pick_unit.sv
